// File: rtl/core/utf8cc_pkg.sv
// ----------------------------------------------------------------------------
// utf8cc_pkg
// Types, constants and case-mapping helpers shared by the UTF-8 case converter.
// ----------------------------------------------------------------------------
package utf8cc_pkg;

    localparam int MAX_SEQ_BYTES = 4;

    // unit queue between decoder and encoder
    localparam int UQ_DEPTH = 4;
    localparam int UQ_AW    = $clog2(UQ_DEPTH);

    // output buffer in front of the result ports
    localparam int OB_DEPTH = 2;
    localparam int OB_AW    = $clog2(OB_DEPTH);

    localparam logic [7:0]  CONT_MASK  = 8'h3F;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [15:0] BAD_UNIT   = 16'h003F;
    localparam logic [15:0] MASK_1B    = 16'h007F;
    localparam logic [15:0] MASK_2B    = 16'h07FF;
    localparam logic [15:0] MASK_3B    = 16'hFFFF;

    localparam logic MODE_UPPER = 1'b0;
    localparam logic MODE_LOWER = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // one decoded character
    typedef struct packed {
        logic [15:0] code;
        logic        last;
    } t_unit;

    typedef struct packed {
        logic  valid;
        t_unit unit;
    } t_uq_wr;

    function automatic logic [15:0] map_case(input logic [15:0] c, input logic mode);
        logic [15:0] r;
        r = c;
        if (mode == MODE_UPPER) begin
            if (c >= 16'h0061 && c <= 16'h007A)      r = c - 16'h0020;
            else if (c >= 16'hFF41 && c <= 16'hFF5A) r = c - 16'h0020;
            else if (c >= 16'h0561 && c < 16'h0587)  r = c - 16'h0030;
        end else begin
            if (c >= 16'h0041 && c <= 16'h005A)      r = c + 16'h0020;
            else if (c >= 16'h0531 && c <= 16'h0556) r = c + 16'h0030;
            else if (c >= 16'hFF21 && c <= 16'hFF3A) r = c + 16'h0020;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/utf8_case_convert_core.sv
// ----------------------------------------------------------------------------
// utf8_case_convert_core
// Streaming UTF-8 case converter, queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while full is low and gives one converted
// byte per cycle while empty is low. Each character is decoded to a 16-bit
// unit (longer code points keep their low 16 bits), mapped to upper or lower
// case per case_mode, and re-encoded as 1 to 3 bytes. The decoder drops
// finished units into a 4-entry queue; the encoder drains it one output byte
// per cycle while the result buffer has room, which sets the sustained rate
// at one byte per cycle each way. A unit passes through the unit queue and
// then the output buffer before it reaches the result ports. Bad lead or
// stray continuation bytes come out as '?'; a string cut short is padded with
// zero bits. case_mode is to be written only while the block is idle.
module utf8_case_convert_core
    import utf8cc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_case_mode
);

    logic   r_case_mode;
    logic   accept;
    t_uq_wr uq_wr;
    t_unit  uq_head;
    logic   uq_full, uq_empty, uq_rd;

    assign o_cfg_ready = 1'b1;
    assign full        = uq_full;
    assign accept      = push && !uq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode <= MODE_UPPER;
        end else if (i_cfg_valid) begin
            r_case_mode <= i_cfg_case_mode;
        end
    end

    utf8cc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_wr     (uq_wr)
    );

    utf8cc_uq u_uq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (uq_wr),
        .i_rd    (uq_rd),
        .o_head  (uq_head),
        .o_full  (uq_full),
        .o_empty (uq_empty)
    );

    utf8cc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_case_mode (r_case_mode),
        .i_head      (uq_head),
        .i_uq_empty  (uq_empty),
        .o_uq_rd     (uq_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

// File: rtl/core/utf8cc_front.sv
// ----------------------------------------------------------------------------
// utf8cc_front
// Byte-level UTF-8 decoder: gathers a character and pushes one 16-bit unit.
// ----------------------------------------------------------------------------
module utf8cc_front
    import utf8cc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_uq_wr   o_wr
);

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_rem,  n_rem;
    logic [15:0] r_mask, n_mask;

    logic [7:0]  b;
    logic [15:0] pad;
    logic        done;

    assign b = i_item.in_byte;

    always_comb begin
        n_pend = r_pend;
        n_rem  = r_rem;
        n_mask = r_mask;
        if (r_rem != 2'd0) begin
            // any byte counts as a continuation here
            n_pend = {r_pend[9:0], b[5:0]};
            n_rem  = r_rem - 2'd1;
        end else if (b[7] == 1'b0) begin
            n_pend = {8'h00, b};
            n_mask = MASK_1B;
        end else if ((b & LEAD3) == LEAD2 && MAX_SEQ_BYTES >= 2) begin
            n_pend = {8'h00, b};
            n_mask = MASK_2B;
            n_rem  = 2'd1;
        end else if (b[7:4] == 4'hE && MAX_SEQ_BYTES >= 3) begin
            n_pend = {8'h00, b};
            n_mask = MASK_3B;
            n_rem  = 2'd2;
        end else if (b[7:3] == 5'h1E && MAX_SEQ_BYTES >= 4) begin
            n_pend = {8'h00, b};
            n_mask = MASK_3B;
            n_rem  = 2'd3;
        end else begin
            n_pend = BAD_UNIT;
            n_mask = MASK_3B;
        end
    end

    // string cut short: missing continuations are zero bits
    always_comb begin
        case (n_rem)
            2'd0:    pad = n_pend;
            2'd1:    pad = {n_pend[9:0], 6'd0};
            2'd2:    pad = {n_pend[3:0], 12'd0};
            default: pad = 16'h0000;
        endcase
    end

    assign done = (n_rem == 2'd0) || i_item.in_last;

    assign o_wr.valid     = i_accept && done;
    assign o_wr.unit.code = pad & n_mask;
    assign o_wr.unit.last = i_item.in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_rem  <= '0;
            r_mask <= '0;
        end else if (i_accept) begin
            if (done) begin
                r_pend <= '0;
                r_rem  <= '0;
                r_mask <= '0;
            end else begin
                r_pend <= n_pend;
                r_rem  <= n_rem;
                r_mask <= n_mask;
            end
        end
    end

endmodule

// File: rtl/core/utf8cc_uq.sv
// ----------------------------------------------------------------------------
// utf8cc_uq
// Short queue of decoded units between the decoder and the encoder.
// ----------------------------------------------------------------------------
module utf8cc_uq
    import utf8cc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_uq_wr i_wr,
    input  logic   i_rd,
    output t_unit  o_head,
    output logic   o_full,
    output logic   o_empty
);

    t_unit            r_mem [UQ_DEPTH];
    logic [UQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [UQ_AW:0]   r_cnt,    n_cnt;

    logic do_wr, do_rd;

    assign o_full  = (r_cnt == (UQ_AW+1)'(UQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign do_wr = i_wr.valid && !o_full;
    assign do_rd = i_rd && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_wr && !do_rd) n_cnt = r_cnt + 1'b1;
        else if (!do_wr && do_rd) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/core/utf8cc_back.sv
// ----------------------------------------------------------------------------
// utf8cc_back
// Case mapper and UTF-8 encoder: a byte per cycle into a result buffer with room.
// ----------------------------------------------------------------------------
module utf8cc_back
    import utf8cc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_case_mode,
    input  t_unit     i_head,
    input  logic      i_uq_empty,
    output logic      o_uq_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [1:0]       r_idx;
    t_out_item        r_ob [OB_DEPTH];
    logic [OB_AW-1:0] r_ob_wr, r_ob_rd;
    logic [OB_AW:0]   r_ob_cnt, n_ob_cnt;

    logic [15:0] c;
    logic [1:0]  n_last_idx;
    logic [7:0]  enc;
    logic        ob_full, adv, at_end, do_pop;

    assign c = map_case(i_head.code, i_case_mode);

    always_comb begin
        if (c < 16'h0080)      n_last_idx = 2'd0;
        else if (c < 16'h0800) n_last_idx = 2'd1;
        else                   n_last_idx = 2'd2;
    end

    always_comb begin
        enc = c[7:0];
        case (n_last_idx)
            2'd1: begin
                if (r_idx == 2'd0) enc = LEAD2 | {3'd0, c[10:6]};
                else               enc = CONT_TAG | {2'd0, c[5:0]};
            end
            2'd2: begin
                if (r_idx == 2'd0)      enc = LEAD3 | {4'd0, c[15:12]};
                else if (r_idx == 2'd1) enc = CONT_TAG | {2'd0, c[11:6]};
                else                    enc = CONT_TAG | {2'd0, c[5:0]};
            end
            default: enc = c[7:0];
        endcase
    end

    assign ob_full = (r_ob_cnt == (OB_AW+1)'(OB_DEPTH));
    assign o_empty = (r_ob_cnt == '0);
    assign o_item  = r_ob[r_ob_rd];

    assign adv     = !i_uq_empty && !ob_full;
    assign at_end  = (r_idx == n_last_idx);
    assign o_uq_rd = adv && at_end;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_ob_cnt = r_ob_cnt;
        if (adv && !do_pop) n_ob_cnt = r_ob_cnt + 1'b1;
        else if (!adv && do_pop) n_ob_cnt = r_ob_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ob[r_ob_wr].out_byte <= enc;
            r_ob[r_ob_wr].out_last <= i_head.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ob_wr  <= '0;
            r_ob_rd  <= '0;
            r_ob_cnt <= '0;
        end else begin
            if (adv) begin
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
                r_ob_wr <= r_ob_wr + 1'b1;
            end
            if (do_pop) r_ob_rd <= r_ob_rd + 1'b1;
            r_ob_cnt <= n_ob_cnt;
        end
    end

endmodule

// File: rtl/core/utf8cc_chk.sv
// ----------------------------------------------------------------------------
// utf8cc_chk
// Port-level checks for the UTF-8 case converter, bound to the top level.
// ----------------------------------------------------------------------------
module utf8cc_chk
    import utf8cc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input t_in_item  i_in_item,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed or vanished before pop");

    // a full unit queue means the encoder has fed the result side
    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input stalled while no result is waiting");

    // the end of a string always completes a character
    a_last_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_in_item.in_last) |-> ##2 !empty)
        else $error("no result after the last byte of a string");

endmodule

bind utf8_case_convert_core utf8cc_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .i_in_item  (i_in_item),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
